/* rtl/mcsg_pkg.sv */
// Package for the midpoint circle span generator.
// Item types, operation codes, register indexes and queue sizing.
// No dependencies.
`default_nettype none

package mcsg_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic REG_FRONT_COLOR = 1'b0;
    localparam logic [15:0] FRONT_COLOR_RESET = 16'hFFFF;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef struct packed {
        logic              operation;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [11:0]        radius;
        logic               filled;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] span_left;
        logic signed [15:0] span_right;
        logic signed [15:0] span_row;
        logic [15:0]        pixel_color;
        logic               last_of_step;
        logic               circle_done;
    } out_item_t;

    typedef struct packed {
        logic fill;
        logic done;
    } job_flags_t;

endpackage

`default_nettype wire

/* rtl/mcsg_front.sv */
// Front end: accepts items, holds the circle state and runs one midpoint
// iteration per step item, pushing the iteration's offsets to the queue.
// Depends on mcsg_pkg.
`default_nettype none

module mcsg_front #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire mcsg_pkg::in_item_t        s_item,
    input  wire logic                      q_ready,
    output logic                           q_push,
    output logic signed [COORD_WIDTH-1:0]  q_cx,
    output logic signed [COORD_WIDTH-1:0]  q_cy,
    output logic signed [COORD_WIDTH-1:0]  q_x,
    output logic signed [COORD_WIDTH-1:0]  q_y,
    output mcsg_pkg::job_flags_t           q_flags
);
    import mcsg_pkg::*;

    localparam logic signed [COORD_WIDTH-1:0] ONE = COORD_WIDTH'(1);

    logic signed [COORD_WIDTH-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [COORD_WIDTH-1:0] x_reg, x_next, y_reg, y_next, e_reg, e_next;
    logic fill_reg, fill_next, busy_reg, busy_next;

    logic accept;
    logic y_inc, x_inc;
    logic signed [COORD_WIDTH-1:0] y1, e1, x2, e2;
    logic [31:0] cx_ext, cy_ext, r_ext, x_init, e_init;

    assign s_ready = q_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        y_inc = (e_reg <= y_reg);
        y1    = y_inc ? y_reg + ONE : y_reg;
        e1    = y_inc ? e_reg + y1 + y1 + ONE : e_reg;
        x_inc = (e_reg > x_reg) || (e1 > y1);
        x2    = x_inc ? x_reg + ONE : x_reg;
        e2    = x_inc ? e1 + x2 + x2 + ONE : e1;
    end

    assign cx_ext = 32'(s_item.center_x);
    assign cy_ext = 32'(s_item.center_y);
    assign r_ext  = 32'(s_item.radius);
    assign x_init = 32'd0 - r_ext;
    assign e_init = 32'd2 - (r_ext << 1);

    assign q_push       = accept && (s_item.operation == OP_STEP) && busy_reg;
    assign q_cx         = cx_reg;
    assign q_cy         = cy_reg;
    assign q_x          = x_reg;
    assign q_y          = y_reg;
    assign q_flags.fill = fill_reg;
    assign q_flags.done = !x2[COORD_WIDTH-1];

    always_comb begin
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        e_next    = e_reg;
        fill_next = fill_reg;
        busy_next = busy_reg;
        if (accept) begin
            if (s_item.operation == OP_START) begin
                cx_next   = cx_ext[COORD_WIDTH-1:0];
                cy_next   = cy_ext[COORD_WIDTH-1:0];
                x_next    = x_init[COORD_WIDTH-1:0];
                y_next    = '0;
                e_next    = e_init[COORD_WIDTH-1:0];
                fill_next = s_item.filled;
                busy_next = 1'b1;
            end else if (busy_reg) begin
                x_next    = x2;
                y_next    = y1;
                e_next    = e2;
                busy_next = x2[COORD_WIDTH-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg   <= '0;
            cy_reg   <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            e_reg    <= '0;
            fill_reg <= 1'b0;
            busy_reg <= 1'b0;
        end else begin
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
            e_reg    <= e_next;
            fill_reg <= fill_next;
            busy_reg <= busy_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_push_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_item.operation == OP_START) |-> !q_push)
        else $error("start item pushed a job");
    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && q_flags.done) |=> !busy_reg)
        else $error("still busy after final iteration");
`endif

endmodule

`default_nettype wire

/* rtl/mcsg_queue.sv */
// Short job queue between front and back end.
// Holds iteration offsets and flags. Depends on mcsg_pkg.
`default_nettype none

module mcsg_queue #(
    parameter int WIDTH = 66
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data
);
    import mcsg_pkg::*;

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [QUEUE_CNT_W-1:0] cnt_reg, cnt_next;

    assign push_ready = (cnt_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = slot_reg[rd_reg];

    always_comb begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (push_ready || pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> pop_valid)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

/* rtl/mcsg_back.sv */
// Back end: expands one queued iteration into its two or four spans, one per
// cycle while m_ready allows, into the output register. Depends on mcsg_pkg.
`default_nettype none

module mcsg_back #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    output logic                               q_pop,
    input  wire logic signed [COORD_WIDTH-1:0] q_cx,
    input  wire logic signed [COORD_WIDTH-1:0] q_cy,
    input  wire logic signed [COORD_WIDTH-1:0] q_x,
    input  wire logic signed [COORD_WIDTH-1:0] q_y,
    input  wire mcsg_pkg::job_flags_t          q_flags,
    input  wire logic [15:0]                   front_color,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output mcsg_pkg::out_item_t                m_item
);
    import mcsg_pkg::*;

    function automatic logic [15:0] to_out(input logic signed [COORD_WIDTH-1:0] v);
        logic signed [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    out_item_t  item_reg, item_next;
    logic       load, last;
    logic signed [COORD_WIDTH-1:0] col_l, col_r, row;

    assign load  = q_valid && (!valid_reg || m_ready);
    assign last  = q_flags.fill ? (idx_reg == 2'd1) : (idx_reg == 2'd3);
    assign q_pop = load && last;

    always_comb begin
        col_l = q_cx + q_x;
        col_r = q_cx - q_x;
        row   = q_cy + q_y;
        if (q_flags.fill) begin
            if (idx_reg[0]) begin
                row = q_cy - q_y;
            end
        end else begin
            case (idx_reg)
                2'd0: begin
                    col_l = q_cx - q_x;
                    row   = q_cy + q_y;
                end
                2'd1: begin
                    col_l = q_cx - q_y;
                    row   = q_cy - q_x;
                end
                2'd2: begin
                    col_l = q_cx + q_x;
                    row   = q_cy - q_y;
                end
                default: begin
                    col_l = q_cx + q_y;
                    row   = q_cy + q_x;
                end
            endcase
            col_r = col_l;
        end
    end

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        item_next  = item_reg;
        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next             = 1'b1;
            item_next.span_left    = to_out(col_l);
            item_next.span_right   = to_out(col_r);
            item_next.span_row     = to_out(row);
            item_next.pixel_color  = front_color;
            item_next.last_of_step = last;
            item_next.circle_done  = last && q_flags.done;
            idx_next               = last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

`ifndef ASSERT_OFF
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.circle_done) |-> m_item.last_of_step)
        else $error("circle done on a span that is not last of step");
    a_fill_two_spans: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_flags.fill) |-> !idx_reg[1])
        else $error("filled iteration past its second span");
`endif

endmodule

`default_nettype wire

/* rtl/midpoint_circle_span_generator_core.sv */
// Midpoint circle span generator, top level: APB color register,
// front end, job queue and span back end. Depends on mcsg_pkg.
// The spans of a step pass through the job queue and the output register.
// Throughput: one span per cycle from the output register while m_ready is
// high; a step gives four spans in outline mode and two in filled mode.
// Reset (aresetn low, synchronous): circle idle, front_color = 0xFFFF.
`default_nettype none

module midpoint_circle_span_generator_core #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire mcsg_pkg::in_item_t  s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output mcsg_pkg::out_item_t      m_item,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import mcsg_pkg::*;

    localparam int JOB_W = 4 * COORD_WIDTH + $bits(job_flags_t);

    logic [15:0] color_reg, color_next;

    logic q_push, q_ready, q_valid, q_pop;
    logic signed [COORD_WIDTH-1:0] f_cx, f_cy, f_x, f_y;
    logic signed [COORD_WIDTH-1:0] b_cx, b_cy, b_x, b_y;
    job_flags_t f_flags, b_flags;
    logic [JOB_W-1:0] push_data, pop_data;

    assign pready = 1'b1;

    always_comb begin
        color_next = color_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == REG_FRONT_COLOR)) begin
            color_next = pwdata[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg <= FRONT_COLOR_RESET;
        end else begin
            color_reg <= color_next;
        end
    end

    assign prdata = (paddr[2] == REG_FRONT_COLOR) ? 32'(color_reg) : 32'd0;

    mcsg_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_cx    (f_cx),
        .q_cy    (f_cy),
        .q_x     (f_x),
        .q_y     (f_y),
        .q_flags (f_flags)
    );

    assign push_data = {f_cx, f_cy, f_x, f_y, f_flags};
    assign {b_cx, b_cy, b_x, b_y, b_flags} = pop_data;

    mcsg_queue #(.WIDTH(JOB_W)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_ready (q_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (pop_data)
    );

    mcsg_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_cx        (b_cx),
        .q_cy        (b_cy),
        .q_x         (b_x),
        .q_y         (b_y),
        .q_flags     (b_flags),
        .front_color (color_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

endmodule

`default_nettype wire

/* tb/sv/midpoint_circle_span_generator_core_tb.sv */
// Self-checking testbench for midpoint_circle_span_generator_core: directed rows, then
// random circles across several front_color settings. Depends on mcsg_pkg and the RTL;
// a built-in circle rasterizer predicts the untyped rows' spans; all are checked in order.
module midpoint_circle_span_generator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mcsg_pkg::*;

    typedef struct {
        in_item_t  item;
        bit        typed;
        int        count;
        out_item_t span;
        bit        done;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_item;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // circle state mirrored by the span predictor
    logic signed [15:0] ctr_x, ctr_y, off_x, off_y, err_t;
    logic               fill_mode;
    logic               circle_busy;
    logic [15:0]        front_color;

    out_item_t span_q[$];
    stim_row_t dir_rows[$];
    int        errors = 0;
    int        live_items = 0;
    int        phase_idx = -1;
    bit        steady = 0;

    midpoint_circle_span_generator_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic out_item_t span_at(logic [15:0] l, logic [15:0] r, logic [15:0] row);
        out_item_t s;
        s = '0;
        s.span_left   = l;
        s.span_right  = r;
        s.span_row    = row;
        s.pixel_color = front_color;
        return s;
    endfunction

    function automatic out_item_t pix(logic [15:0] col, logic [15:0] row);
        out_item_t s;
        s = '0;
        s.span_left   = col;
        s.span_right  = col;
        s.span_row    = row;
        s.pixel_color = FRONT_COLOR_RESET;
        return s;
    endfunction

    function automatic in_item_t rand_item(logic op);
        logic [63:0] raw;
        in_item_t    it;
        raw = {$urandom(), $urandom()};
        it = raw[$bits(in_item_t)-1:0];
        it.operation = op;
        return it;
    endfunction

    function automatic in_item_t start_item(logic [15:0] cx, logic [15:0] cy,
                                            logic [11:0] r, logic f);
        in_item_t it;
        it = '0;
        it.operation = OP_START;
        it.center_x  = cx;
        it.center_y  = cy;
        it.radius    = r;
        it.filled    = f;
        return it;
    endfunction

    // one start or one iteration of the midpoint circle loop; returns the number of spans
    function automatic int rasterize_step(input in_item_t it, output out_item_t sp[4]);
        logic signed [15:0] x, y, e, r;
        int                 n;
        n = 0;
        if (it.operation == OP_START) begin
            ctr_x       = it.center_x;
            ctr_y       = it.center_y;
            off_x       = 16'd0 - {4'd0, it.radius};
            off_y       = '0;
            err_t       = 16'd2 - ({4'd0, it.radius} << 1);
            fill_mode   = it.filled;
            circle_busy = 1'b1;
            return 0;
        end
        if (!circle_busy)
            return 0;
        x = off_x;
        y = off_y;
        e = err_t;
        if (fill_mode) begin
            sp[0] = span_at(ctr_x + x, ctr_x - x, ctr_y + y);
            sp[1] = span_at(ctr_x + x, ctr_x - x, ctr_y - y);
            n = 2;
        end else begin
            sp[0] = span_at(ctr_x - x, ctr_x - x, ctr_y + y);
            sp[1] = span_at(ctr_x - y, ctr_x - y, ctr_y - x);
            sp[2] = span_at(ctr_x + x, ctr_x + x, ctr_y - y);
            sp[3] = span_at(ctr_x + y, ctr_x + y, ctr_y + x);
            n = 4;
        end
        r = e;
        if (r <= y) begin
            y = y + 16'sd1;
            e = e + 2 * y + 1;
        end
        if (r > x || e > y) begin
            x = x + 16'sd1;
            e = e + 2 * x + 1;
        end
        off_x = x;
        off_y = y;
        err_t = e;
        sp[n-1].last_of_step = 1'b1;
        if (!x[15]) begin
            circle_busy = 1'b0;
            sp[n-1].circle_done = 1'b1;
        end
        return n;
    endfunction

    task automatic send_item(input stim_row_t row);
        out_item_t sp[4];
        out_item_t s;
        int        n;
        if (!steady) begin
            while ($urandom_range(0, 99) < 11) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_item  <= row.item;
        do @(posedge aclk); while (!s_ready);
        if (row.item.operation == OP_START || circle_busy)
            live_items++;
        n = rasterize_step(row.item, sp);
        if (row.typed) begin
            for (int i = 0; i < row.count; i++) begin
                s = row.span;
                s.last_of_step = (i == row.count - 1);
                s.circle_done  = row.done && (i == row.count - 1);
                span_q.push_back(s);
            end
        end else begin
            for (int i = 0; i < n; i++)
                span_q.push_back(sp[i]);
        end
    endtask

    task automatic send_plain(input in_item_t it);
        send_item('{it, 1'b0, 0, '0, 1'b0});
    endtask

    task automatic settle(input int cycles);
        s_valid <= 1'b0;
        while (span_q.size() != 0)
            @(posedge aclk);
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic write_color(input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_FRONT_COLOR, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        front_color = val;
    endtask

    function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // result side: random stalls, one long hold in phase 1, none in phase 2
    initial begin
        out_item_t exp_s;
        int        hold_left;
        bit        hold_used;
        hold_left = 0;
        hold_used = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (span_q.size() == 0) begin
                    $error("span with no expectation: %p", m_item);
                    errors++;
                end else begin
                    exp_s = span_q.pop_front();
                    check_field("span_left", exp_s.span_left, m_item.span_left);
                    check_field("span_right", exp_s.span_right, m_item.span_right);
                    check_field("span_row", exp_s.span_row, m_item.span_row);
                    check_field("pixel_color", exp_s.pixel_color, m_item.pixel_color);
                    check_field("last_of_step", exp_s.last_of_step, m_item.last_of_step);
                    check_field("circle_done", exp_s.circle_done, m_item.circle_done);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (phase_idx == 1 && !hold_used && m_valid) begin
                hold_used = 1;
                hold_left = 300;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(0, 99) >= 11);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("[midpoint_circle_span_generator_core] ERROR");
        $finish;
    end

    initial begin
        in_item_t    it;
        logic [15:0] colors [4];
        int          target;
        int          steps;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_item      = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        ctr_x       = '0;
        ctr_y       = '0;
        off_x       = '0;
        off_y       = '0;
        err_t       = '0;
        fill_mode   = 1'b0;
        circle_busy = 1'b0;
        front_color = FRONT_COLOR_RESET;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // step while idle, zero radius at the corners, wrap, max radius, restart
        dir_rows.push_back('{rand_item(OP_STEP), 1'b1, 0, '0, 1'b0});
        dir_rows.push_back('{start_item(16'h0000, 16'h0000, 12'd0, 1'b0), 1'b1, 0, '0, 1'b0});
        dir_rows.push_back('{rand_item(OP_STEP), 1'b1, 4, pix(16'h0000, 16'h0000), 1'b1});
        dir_rows.push_back('{rand_item(OP_STEP), 1'b1, 0, '0, 1'b0});
        dir_rows.push_back('{start_item(16'h7FFF, 16'h8000, 12'd0, 1'b1), 1'b1, 0, '0, 1'b0});
        dir_rows.push_back('{rand_item(OP_STEP), 1'b1, 2, pix(16'h7FFF, 16'h8000), 1'b1});
        dir_rows.push_back('{start_item(16'h8000, 16'h7FFF, 12'd0, 1'b0), 1'b1, 0, '0, 1'b0});
        dir_rows.push_back('{rand_item(OP_STEP), 1'b1, 4, pix(16'h8000, 16'h7FFF), 1'b1});
        dir_rows.push_back('{start_item(16'd100, -16'sd50, 12'd1, 1'b0), 1'b0, 0, '0, 1'b0});
        dir_rows.push_back('{rand_item(OP_STEP), 1'b0, 0, '0, 1'b0});
        dir_rows.push_back('{rand_item(OP_STEP), 1'b0, 0, '0, 1'b0});
        dir_rows.push_back('{start_item(16'h7FFF, 16'h7FFF, 12'd5, 1'b1), 1'b0, 0, '0, 1'b0});
        repeat (4) dir_rows.push_back('{rand_item(OP_STEP), 1'b0, 0, '0, 1'b0});
        dir_rows.push_back('{start_item(16'h8000, 16'h8000, 12'hFFF, 1'b0), 1'b0, 0, '0, 1'b0});
        dir_rows.push_back('{in_item_t'('1), 1'b0, 0, '0, 1'b0});
        dir_rows.push_back('{rand_item(OP_STEP), 1'b0, 0, '0, 1'b0});
        dir_rows.push_back('{start_item(16'hFFFF, 16'h0001, 12'd3, 1'b1), 1'b0, 0, '0, 1'b0});
        repeat (4) dir_rows.push_back('{rand_item(OP_STEP), 1'b0, 0, '0, 1'b0});
        foreach (dir_rows[i])
            send_item(dir_rows[i]);

        colors = '{16'h0000, 16'hFFFF, 16'h5AA5, 16'($urandom())};
        for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
            settle(8);
            write_color(colors[phase_idx]);
            steady = (phase_idx == 2);
            target = live_items + 45;
            while (live_items < target) begin
                if ($urandom_range(0, 99) < 10) begin
                    // stray steps and lone random starts
                    send_plain(rand_item($urandom_range(0, 1) ? OP_STEP : OP_START));
                end else begin
                    it = rand_item(OP_START);
                    if ($urandom_range(0, 19) != 0)
                        it.radius = 12'($urandom_range(0, 24));
                    send_plain(it);
                    steps = 0;
                    while (circle_busy && steps < 40 && $urandom_range(0, 99) >= 3) begin
                        send_plain(rand_item(OP_STEP));
                        steps++;
                    end
                end
            end
            if (circle_busy) begin
                send_plain(start_item(16'h0000, 16'h0000, 12'd0, 1'b0));
                send_plain(rand_item(OP_STEP));
            end
        end
        steady = 0;
        settle(20);
        if (errors == 0)
            $display("[midpoint_circle_span_generator_core] OK");
        else
            $display("[midpoint_circle_span_generator_core] ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/mcsg_pkg.sv
rtl/mcsg_front.sv
rtl/mcsg_queue.sv
rtl/mcsg_back.sv
rtl/midpoint_circle_span_generator_core.sv
tb/sv/midpoint_circle_span_generator_core_tb.sv
